[rtl/tss_pkg.sv]
// -----------------------------------------------------------------------------
// Test segment sequencer package
// Shared types, codes and constants for the sequencer controller and datapath.
// -----------------------------------------------------------------------------
package tss_pkg;

   // Item operation codes.
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_START     = 3'd1;
   localparam logic [2:0] OP_ABORT     = 3'd2;
   localparam logic [2:0] OP_WR_SEG    = 3'd3;
   localparam logic [2:0] OP_WR_LIMIT  = 3'd4;
   localparam logic [2:0] OP_WR_PARAM  = 3'd5;

   // Machine phases as reported on the result word.
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_SETUP = 3'd1;
   localparam logic [2:0] PH_RUN   = 3'd2;
   localparam logic [2:0] PH_DONE  = 3'd3;
   localparam logic [2:0] PH_ABORT = 3'd4;

   // Drive commands.
   localparam logic [1:0] DRV_NONE = 2'd0;
   localparam logic [1:0] DRV_UP   = 2'd1;
   localparam logic [1:0] DRV_DOWN = 2'd2;
   localparam logic [1:0] DRV_STOP = 2'd3;

   // Segment kinds and limit sources.
   localparam logic [1:0] KIND_UP   = 2'd0;
   localparam logic [1:0] KIND_DOWN = 2'd1;
   localparam logic [1:0] SRC_FORCE = 2'd0;
   localparam logic [1:0] SRC_EXT   = 2'd1;
   localparam logic [1:0] SRC_TIME  = 2'd2;
   localparam logic [1:0] SRC_NONE  = 2'd3;

   localparam logic [15:0] SPEED_CODE   = 16'd1001;
   localparam logic [31:0] UP_DEFAULT   = 32'h000A_0000;
   localparam logic [31:0] DOWN_DEFAULT = 32'h0005_0000;

   // Controller states, one-hot.
   typedef enum logic [5:0] {
      ST_WAIT  = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_PARAM = 6'b000100,
      ST_LIMIT = 6'b001000,
      ST_APPLY = 6'b010000,
      ST_SEND  = 6'b100000
   } ctrl_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic capture;     // latch the request word
      logic do_write;    // perform a table write for the latched word
      logic rd_seg;      // read segment descriptor
      logic walk_start;  // reset walk index and flags
      logic walk_step;   // evaluate one limit/parameter entry
      logic apply;       // update machine state from the evaluation
      logic load_rsp;    // load the result register
   } dp_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic is_run_tick; // the latched item is a run-phase tick, not aborted, with a segment left
      logic walk_done;   // all entries evaluated
   } dp_stat_type;

endpackage

[rtl/tss_ram.sv]
// -----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// -----------------------------------------------------------------------------
module tss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tss_ctrl.sv]
// -----------------------------------------------------------------------------
// Sequencer controller
// Steps each accepted word through decode, a table walk for a running tick,
// and result issue.
module tss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tss_pkg::dp_cmd_type  cmd,
   input  tss_pkg::dp_stat_type stat
);

   tss_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != tss_pkg::ST_WAIT);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         tss_pkg::ST_WAIT: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = tss_pkg::ST_DECODE;
            end
         end
         tss_pkg::ST_DECODE: begin
            cmd.do_write = 1'b1;
            cmd.rd_seg   = 1'b1;
            if (stat.is_run_tick) begin
               state_in = tss_pkg::ST_PARAM;
            end else begin
               state_in = tss_pkg::ST_APPLY;
            end
         end
         tss_pkg::ST_PARAM: begin
            // Segment descriptor read lands here.
            cmd.walk_start = 1'b1;
            state_in       = tss_pkg::ST_LIMIT;
         end
         tss_pkg::ST_LIMIT: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_done) begin
               state_in = tss_pkg::ST_APPLY;
            end
         end
         tss_pkg::ST_APPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.apply    = 1'b1;
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tss_pkg::ST_SEND;
            end
         end
         tss_pkg::ST_SEND: begin
            state_in = tss_pkg::ST_WAIT;
         end
         default: state_in = tss_pkg::ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tss_pkg::ST_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/tss_datapath.sv]
// -----------------------------------------------------------------------------
// Sequencer datapath
// Segment program tables, walk over limits and parameters, and machine state.
// -----------------------------------------------------------------------------
module tss_datapath #(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_LIMITS   = 4,
   parameter int MAX_PARAMS   = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tss_pkg::dp_cmd_type  cmd,
   output tss_pkg::dp_stat_type stat,
   input  logic [2:0]           req_op,
   input  logic [4:0]           req_seg_sel,
   input  logic [1:0]           req_slot_sel,
   input  logic [1:0]           req_seg_kind,
   input  logic [2:0]           req_limit_total,
   input  logic [2:0]           req_param_total,
   input  logic                 req_limit_enabled,
   input  logic                 req_limit_is_above,
   input  logic [15:0]          req_entry_code,
   input  logic signed [31:0]   req_entry_value,
   input  logic signed [31:0]   req_force_sample,
   input  logic signed [31:0]   req_extension_sample,
   output logic [2:0]           rsp_machine_state,
   output logic [1:0]           rsp_drive_command,
   output logic signed [31:0]   rsp_drive_speed,
   output logic [4:0]           rsp_active_segment,
   output logic                 rsp_segment_advanced
);

   localparam int SW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int LW  = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1;
   localparam int PW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int LCW = $clog2(MAX_LIMITS + 1);
   localparam int PCW = $clog2(MAX_PARAMS + 1);
   localparam int TW  = $clog2(MAX_SEGMENTS + 1);
   localparam int WCW = ((LCW > PCW) ? LCW : PCW) + 1;
   localparam int KINDW = 2 + LCW + PCW;
   localparam int LIMW  = 4 + 32;
   localparam int PARW  = 16 + 32;
   localparam int LDEPTH = MAX_SEGMENTS * MAX_LIMITS;
   localparam int PDEPTH = MAX_SEGMENTS * MAX_PARAMS;
   localparam int LAW = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
   localparam int PAW = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

   // Latched request word.
   logic [2:0]         op_ff;
   logic [4:0]         seg_ff;
   logic [1:0]         slot_ff, kind_ff;
   logic [2:0]         ltot_ff, ptot_ff;
   logic               en_ff, above_ff;
   logic [15:0]        code_ff;
   logic signed [31:0] value_ff, force_ff, ext_ff;

   // Machine state.
   logic [2:0]  phase_ff, phase_in;
   logic        start_ff, start_in, abort_ff, abort_in;
   logic [TW-1:0] total_ff, total_in, now_ff, now_in;
   logic [31:0] elapsed_ff, elapsed_in;

   // Walk state.
   logic [WCW-1:0] idx_ff;
   logic [KINDW-1:0] kdesc_ff;
   logic           met_ff, spd_found_ff;
   logic [31:0]    spd_ff;
   logic           pending_ff;   // RAM read issued last cycle

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         seg_ff   <= req_seg_sel;
         slot_ff  <= req_slot_sel;
         kind_ff  <= req_seg_kind;
         ltot_ff  <= req_limit_total;
         ptot_ff  <= req_param_total;
         en_ff    <= req_limit_enabled;
         above_ff <= req_limit_is_above;
         code_ff  <= req_entry_code;
         value_ff <= req_entry_value;
         force_ff <= req_force_sample;
         ext_ff   <= req_extension_sample;
      end
   end

   logic seg_ok;
   assign seg_ok = ({27'd0, seg_ff} < MAX_SEGMENTS);

   // Tables.
   logic [KINDW-1:0] kind_wdata, kind_rdata;
   logic [LCW-1:0]   nl_sat;
   logic [PCW-1:0]   np_sat;
   always_comb begin
      nl_sat = ({29'd0, ltot_ff} < MAX_LIMITS) ? LCW'(ltot_ff) : LCW'(MAX_LIMITS);
      np_sat = ({29'd0, ptot_ff} < MAX_PARAMS) ? PCW'(ptot_ff) : PCW'(MAX_PARAMS);
      kind_wdata = {kind_ff, nl_sat, np_sat};
   end

   logic [1:0] src_w;
   assign src_w = (code_ff < 16'd3) ? code_ff[1:0] : tss_pkg::SRC_NONE;

   logic [SW-1:0] cur_seg;
   assign cur_seg = SW'(now_ff);

   tss_ram #(.WIDTH(KINDW), .DEPTH(MAX_SEGMENTS)) u_kind (
      .clock   (clock),
      .wr_en   (cmd.do_write && op_ff == tss_pkg::OP_WR_SEG && seg_ok),
      .wr_addr (SW'(seg_ff)),
      .wr_data (kind_wdata),
      .rd_addr (cur_seg),
      .rd_data (kind_rdata)
   );

   logic [LIMW-1:0] lim_rdata;
   logic [PARW-1:0] par_rdata;
   logic [LW-1:0]   lslot_rd;
   logic [PW-1:0]   pslot_rd;
   assign lslot_rd = LW'(idx_ff);
   assign pslot_rd = PW'(idx_ff);

   logic [LAW-1:0] lim_waddr, lim_raddr;
   logic [PAW-1:0] par_waddr, par_raddr;
   assign lim_waddr = LAW'(SW'(seg_ff) * MAX_LIMITS + LW'(slot_ff));
   assign lim_raddr = LAW'(cur_seg * MAX_LIMITS + lslot_rd);
   assign par_waddr = PAW'(SW'(seg_ff) * MAX_PARAMS + PW'(slot_ff));
   assign par_raddr = PAW'(cur_seg * MAX_PARAMS + pslot_rd);

   tss_ram #(.WIDTH(LIMW), .DEPTH(LDEPTH)) u_limit (
      .clock   (clock),
      .wr_en   (cmd.do_write && op_ff == tss_pkg::OP_WR_LIMIT && seg_ok &&
                ({30'd0, slot_ff} < MAX_LIMITS)),
      .wr_addr (lim_waddr),
      .wr_data ({en_ff, above_ff, src_w, value_ff}),
      .rd_addr (lim_raddr),
      .rd_data (lim_rdata)
   );

   tss_ram #(.WIDTH(PARW), .DEPTH(PDEPTH)) u_param (
      .clock   (clock),
      .wr_en   (cmd.do_write && op_ff == tss_pkg::OP_WR_PARAM && seg_ok &&
                ({30'd0, slot_ff} < MAX_PARAMS)),
      .wr_addr (par_waddr),
      .wr_data ({code_ff, value_ff}),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   // A run tick that still has a segment to drive walks the tables.
   assign stat.is_run_tick = (op_ff == tss_pkg::OP_TICK) && (phase_ff == tss_pkg::PH_RUN) &&
                             !abort_ff && (now_ff < total_ff);

   // Walk: one RAM read per cycle, evaluated the cycle after.
   logic [LCW-1:0] nlim;
   logic [PCW-1:0] npar;
   logic [WCW-1:0] walk_len;
   assign nlim = kdesc_ff[PCW +: LCW];
   assign npar = kdesc_ff[PCW-1:0];
   assign walk_len = (WCW'(nlim) > WCW'(npar)) ? WCW'(nlim) : WCW'(npar);
   assign stat.walk_done = pending_ff && (idx_ff >= walk_len);

   // Limit comparison for the entry read last cycle. The elapsed time in
   // Q32.16 needs 48 bits unsigned, so one extra bit keeps it positive.
   logic signed [48:0] act, ref_v;
   logic               lim_hit;
   always_comb begin
      ref_v = 49'(signed'(lim_rdata[31:0]));
      unique case (lim_rdata[33:32])
         tss_pkg::SRC_FORCE: act = 49'(force_ff);
         tss_pkg::SRC_EXT:   act = 49'(ext_ff);
         default:            act = signed'({1'b0, elapsed_in, 16'd0});
      endcase
      lim_hit = lim_rdata[35] && (lim_rdata[33:32] != tss_pkg::SRC_NONE) &&
                (lim_rdata[34] ? (act > ref_v) : (act < ref_v));
   end

   logic [WCW-1:0] prev_idx;
   assign prev_idx = idx_ff - WCW'(1);

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         kdesc_ff     <= kind_rdata;
         idx_ff       <= '0;
         met_ff       <= 1'b0;
         spd_found_ff <= 1'b0;
         spd_ff       <= '0;
         pending_ff   <= 1'b0;
      end else if (cmd.walk_step && !stat.walk_done) begin
         idx_ff     <= idx_ff + WCW'(1);
         pending_ff <= 1'b1;
         if (pending_ff) begin
            if (prev_idx < WCW'(nlim) && lim_hit) begin
               met_ff <= 1'b1;
            end
            if (prev_idx < WCW'(npar) && !spd_found_ff &&
                par_rdata[47:32] == tss_pkg::SPEED_CODE) begin
               spd_found_ff <= 1'b1;
               spd_ff       <= par_rdata[31:0];
            end
         end
      end else if (stat.walk_done) begin
         if (prev_idx < WCW'(nlim) && lim_hit) begin
            met_ff <= 1'b1;
         end
         if (prev_idx < WCW'(npar) && !spd_found_ff &&
             par_rdata[47:32] == tss_pkg::SPEED_CODE) begin
            spd_found_ff <= 1'b1;
            spd_ff       <= par_rdata[31:0];
         end
         pending_ff <= 1'b0;
      end
   end

   // Elapsed count as seen after the increment of this tick.
   always_comb begin
      elapsed_in = (elapsed_ff != 32'hFFFF_FFFF) ? elapsed_ff + 32'd1 : elapsed_ff;
   end

   // Item semantics and result.
   logic [1:0]  drv;
   logic [31:0] spd;
   logic        adv;
   logic [31:0] elapsed_nx;
   logic [TW-1:0] seg_sat;
   always_comb begin
      phase_in   = phase_ff;
      start_in   = start_ff;
      abort_in   = abort_ff;
      total_in   = total_ff;
      now_in     = now_ff;
      elapsed_nx = elapsed_ff;
      drv        = tss_pkg::DRV_NONE;
      spd        = '0;
      adv        = 1'b0;
      seg_sat    = ({27'd0, seg_ff} < MAX_SEGMENTS) ? TW'(seg_ff) : TW'(MAX_SEGMENTS);
      unique case (op_ff)
         tss_pkg::OP_START: begin
            if (phase_ff == tss_pkg::PH_IDLE || phase_ff == tss_pkg::PH_DONE ||
                phase_ff == tss_pkg::PH_ABORT) begin
               total_in = seg_sat;
               start_in = 1'b1;
               phase_in = tss_pkg::PH_IDLE;
            end
         end
         tss_pkg::OP_ABORT: abort_in = 1'b1;
         tss_pkg::OP_TICK: begin
            unique case (phase_ff)
               tss_pkg::PH_IDLE: begin
                  if (start_ff && total_ff != '0) begin
                     phase_in = tss_pkg::PH_SETUP;
                     start_in = 1'b0;
                  end
                  abort_in = 1'b0;
               end
               tss_pkg::PH_SETUP: begin
                  if (abort_ff) begin
                     phase_in = tss_pkg::PH_ABORT;
                     drv      = tss_pkg::DRV_STOP;
                  end else begin
                     now_in     = '0;
                     elapsed_nx = '0;
                     phase_in   = tss_pkg::PH_RUN;
                  end
               end
               tss_pkg::PH_RUN: begin
                  if (abort_ff) begin
                     drv      = tss_pkg::DRV_STOP;
                     phase_in = tss_pkg::PH_ABORT;
                  end else if (now_ff >= total_ff) begin
                     drv      = tss_pkg::DRV_STOP;
                     phase_in = tss_pkg::PH_DONE;
                  end else begin
                     elapsed_nx = elapsed_in;
                     if (kdesc_ff[KINDW-1 -: 2] == tss_pkg::KIND_UP) begin
                        drv = tss_pkg::DRV_UP;
                        spd = spd_found_ff ? spd_ff : tss_pkg::UP_DEFAULT;
                     end else if (kdesc_ff[KINDW-1 -: 2] == tss_pkg::KIND_DOWN) begin
                        drv = tss_pkg::DRV_DOWN;
                        spd = spd_found_ff ? spd_ff : tss_pkg::DOWN_DEFAULT;
                     end else begin
                        drv = tss_pkg::DRV_STOP;
                     end
                     if (met_ff) begin
                        adv    = 1'b1;
                        now_in = now_ff + TW'(1);
                        if (now_in >= total_ff) begin
                           drv      = tss_pkg::DRV_STOP;
                           spd      = '0;
                           phase_in = tss_pkg::PH_DONE;
                        end else begin
                           elapsed_nx = '0;
                        end
                     end
                  end
               end
               tss_pkg::PH_DONE: abort_in = 1'b0;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tss_pkg::PH_IDLE;
         start_ff   <= 1'b0;
         abort_ff   <= 1'b0;
         total_ff   <= '0;
         now_ff     <= '0;
         elapsed_ff <= '0;
      end else if (cmd.apply) begin
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         abort_ff   <= abort_in;
         total_ff   <= total_in;
         now_ff     <= now_in;
         elapsed_ff <= elapsed_nx;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_machine_state    <= phase_in;
         rsp_drive_command    <= drv;
         rsp_drive_speed      <= spd;
         rsp_active_segment   <= 5'(now_in);
         rsp_segment_advanced <= adv;
      end
   end

endmodule

[rtl/test_segment_sequencer.sv]
// -----------------------------------------------------------------------------
// Test segment sequencer
// Loads a segment program and sequences a test rig through it on 1 ms ticks.
//
//  Channel   Direction  Handshake           Content
//  req_*     in         req_valid/stall     operation word and samples
//  rsp_*     out        rsp_valid/stall     state, drive order, segment
//
// A word that walks no tables passes through decode and apply, where its
// result is registered, and the next word is taken once the controller has
// passed send and is back in wait. A running tick walks max(limits, parameters,
// 1) entries of the current segment, one table read a cycle, between decode
// and apply. Reset clears the controller and the machine state; program tables
// hold until written. A stalled result holds in its register; the next word is
// still taken, but its result waits in apply until the stall ends.
// -----------------------------------------------------------------------------
module test_segment_sequencer #(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_LIMITS   = 4,
   parameter int MAX_PARAMS   = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic [4:0]         req_seg_sel,
   input  logic [1:0]         req_slot_sel,
   input  logic [1:0]         req_seg_kind,
   input  logic [2:0]         req_limit_total,
   input  logic [2:0]         req_param_total,
   input  logic               req_limit_enabled,
   input  logic               req_limit_is_above,
   input  logic [15:0]        req_entry_code,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_force_sample,
   input  logic signed [31:0] req_extension_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_machine_state,
   output logic [1:0]         rsp_drive_command,
   output logic signed [31:0] rsp_drive_speed,
   output logic [4:0]         rsp_active_segment,
   output logic               rsp_segment_advanced
);

   tss_pkg::dp_cmd_type  cmd;
   tss_pkg::dp_stat_type stat;

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   tss_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .MAX_LIMITS   (MAX_LIMITS),
      .MAX_PARAMS   (MAX_PARAMS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_op               (req_op),
      .req_seg_sel          (req_seg_sel),
      .req_slot_sel         (req_slot_sel),
      .req_seg_kind         (req_seg_kind),
      .req_limit_total      (req_limit_total),
      .req_param_total      (req_param_total),
      .req_limit_enabled    (req_limit_enabled),
      .req_limit_is_above   (req_limit_is_above),
      .req_entry_code       (req_entry_code),
      .req_entry_value      (req_entry_value),
      .req_force_sample     (req_force_sample),
      .req_extension_sample (req_extension_sample),
      .rsp_machine_state    (rsp_machine_state),
      .rsp_drive_command    (rsp_drive_command),
      .rsp_drive_speed      (rsp_drive_speed),
      .rsp_active_segment   (rsp_active_segment),
      .rsp_segment_advanced (rsp_segment_advanced)
   );

endmodule

[rtl/tss_checker.sv]
// -----------------------------------------------------------------------------
// Sequencer port checker
// Watches the top-level ports for handshake and result consistency.
// -----------------------------------------------------------------------------
module tss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_machine_state,
   input logic [1:0]  rsp_drive_command,
   input logic [31:0] rsp_drive_speed
);

   // A stalled result word stays valid and its speed holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_speed))
      else $error("result word changed while stalled");

   // Stop and none carry no speed.
   a_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_drive_command == tss_pkg::DRV_NONE ||
                    rsp_drive_command == tss_pkg::DRV_STOP)
      |-> rsp_drive_speed == 32'd0)
      else $error("speed given with stop or no drive");

   // A moving drive order only comes from the running phase.
   a_move_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_drive_command == tss_pkg::DRV_UP ||
                    rsp_drive_command == tss_pkg::DRV_DOWN)
      |-> rsp_machine_state == tss_pkg::PH_RUN)
      else $error("drive order outside running phase");

   // A word is accepted only once the previous one is under way: after an
   // accept the input side stalls.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

endmodule

bind test_segment_sequencer tss_checker u_tss_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_machine_state (rsp_machine_state),
   .rsp_drive_command (rsp_drive_command),
   .rsp_drive_speed   (rsp_drive_speed)
);
